[src/utf8v_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 validator package
// Shared types and byte constants for the strict UTF-8 string checker.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] BYTE_SPACE    = 8'h20;
  localparam logic [ByteW-1:0] BYTE_DEL      = 8'h7F;
  localparam logic [ByteW-1:0] BYTE_ASCII_HI = 8'h7F;
  localparam logic [ByteW-1:0] BYTE_CONT_LO  = 8'h80;
  localparam logic [ByteW-1:0] BYTE_CONT_HI  = 8'hBF;
  localparam logic [ByteW-1:0] BYTE_8F       = 8'h8F;
  localparam logic [ByteW-1:0] BYTE_90       = 8'h90;
  localparam logic [ByteW-1:0] BYTE_9F       = 8'h9F;
  localparam logic [ByteW-1:0] BYTE_A0       = 8'hA0;
  localparam logic [ByteW-1:0] LEAD2_LO      = 8'hC2;
  localparam logic [ByteW-1:0] LEAD2_HI      = 8'hDF;
  localparam logic [ByteW-1:0] LEAD3_LO      = 8'hE0;
  localparam logic [ByteW-1:0] LEAD3_SURR    = 8'hED;
  localparam logic [ByteW-1:0] LEAD3_HI      = 8'hEF;
  localparam logic [ByteW-1:0] LEAD4_LO      = 8'hF0;
  localparam logic [ByteW-1:0] LEAD4_HI      = 8'hF4;

  // Allowed range of the next continuation byte.
  typedef enum logic [2:0] {
    RNG_ANY = 3'd0,  // 80..BF
    RNG_E0  = 3'd1,  // A0..BF
    RNG_ED  = 3'd2,  // 80..9F
    RNG_F0  = 3'd3,  // 90..BF
    RNG_F4  = 3'd4,  // 80..8F
    RNG_C2  = 3'd5   // A0..BF
  } rng_t;

  typedef struct packed {
    logic [1:0] cont_left;
    rng_t       rng;
    logic       failed;
  } chk_state_t;

  localparam chk_state_t STATE_IDLE = '{cont_left: 2'd0, rng: RNG_ANY, failed: 1'b0};

endpackage

[src/utf8v_step.sv]
// ----------------------------------------------------------------------------
// UTF-8 validator step logic
// Computes the checker state after one byte and the verdict for a final byte.
// ----------------------------------------------------------------------------
module utf8v_step (
  input  utf8v_pkg::chk_state_t      state_i,
  input  logic [utf8v_pkg::ByteW-1:0] byte_i,
  input  logic                       final_i,
  output utf8v_pkg::chk_state_t      state_o,
  output logic                       verdict_o
);

  logic                  cont_ok;
  utf8v_pkg::chk_state_t upd;

  always_comb begin
    unique case (state_i.rng)
      utf8v_pkg::RNG_E0: cont_ok = (byte_i >= utf8v_pkg::BYTE_A0) &&
                                   (byte_i <= utf8v_pkg::BYTE_CONT_HI);
      utf8v_pkg::RNG_ED: cont_ok = (byte_i >= utf8v_pkg::BYTE_CONT_LO) &&
                                   (byte_i <= utf8v_pkg::BYTE_9F);
      utf8v_pkg::RNG_F0: cont_ok = (byte_i >= utf8v_pkg::BYTE_90) &&
                                   (byte_i <= utf8v_pkg::BYTE_CONT_HI);
      utf8v_pkg::RNG_F4: cont_ok = (byte_i >= utf8v_pkg::BYTE_CONT_LO) &&
                                   (byte_i <= utf8v_pkg::BYTE_8F);
      utf8v_pkg::RNG_C2: cont_ok = (byte_i >= utf8v_pkg::BYTE_A0) &&
                                   (byte_i <= utf8v_pkg::BYTE_CONT_HI);
      default:           cont_ok = (byte_i >= utf8v_pkg::BYTE_CONT_LO) &&
                                   (byte_i <= utf8v_pkg::BYTE_CONT_HI);
    endcase
  end

  always_comb begin
    upd = state_i;
    if (state_i.failed) begin
      upd = state_i;
    end else if (state_i.cont_left != 2'd0) begin
      if (cont_ok) begin
        upd.cont_left = state_i.cont_left - 2'd1;
        upd.rng       = utf8v_pkg::RNG_ANY;
      end else begin
        upd.failed = 1'b1;
      end
    end else if (byte_i <= utf8v_pkg::BYTE_ASCII_HI) begin
      if ((byte_i < utf8v_pkg::BYTE_SPACE) || (byte_i == utf8v_pkg::BYTE_DEL)) begin
        upd.failed = 1'b1;
      end
    end else if ((byte_i >= utf8v_pkg::LEAD2_LO) && (byte_i <= utf8v_pkg::LEAD2_HI)) begin
      upd.cont_left = 2'd1;
      upd.rng = (byte_i == utf8v_pkg::LEAD2_LO) ? utf8v_pkg::RNG_C2 : utf8v_pkg::RNG_ANY;
    end else if ((byte_i >= utf8v_pkg::LEAD3_LO) && (byte_i <= utf8v_pkg::LEAD3_HI)) begin
      upd.cont_left = 2'd2;
      if (byte_i == utf8v_pkg::LEAD3_LO) begin
        upd.rng = utf8v_pkg::RNG_E0;
      end else if (byte_i == utf8v_pkg::LEAD3_SURR) begin
        upd.rng = utf8v_pkg::RNG_ED;
      end else begin
        upd.rng = utf8v_pkg::RNG_ANY;
      end
    end else if ((byte_i >= utf8v_pkg::LEAD4_LO) && (byte_i <= utf8v_pkg::LEAD4_HI)) begin
      upd.cont_left = 2'd3;
      if (byte_i == utf8v_pkg::LEAD4_LO) begin
        upd.rng = utf8v_pkg::RNG_F0;
      end else if (byte_i == utf8v_pkg::LEAD4_HI) begin
        upd.rng = utf8v_pkg::RNG_F4;
      end else begin
        upd.rng = utf8v_pkg::RNG_ANY;
      end
    end else begin
      upd.failed = 1'b1;
    end
  end

  assign verdict_o = !upd.failed && (upd.cont_left == 2'd0);
  assign state_o   = final_i ? utf8v_pkg::STATE_IDLE : upd;

endmodule

[src/utf8_text_validator_core.sv]
// ----------------------------------------------------------------------------
// UTF-8 text validator core
// Strict UTF-8 checker for a byte string with a final-byte flag.
// ----------------------------------------------------------------------------
// The block takes one byte beat per cycle and gives one verdict beat for each
// string. The verdict is loaded into the result register as the final byte
// leaves the input register, and out_valid rises from the result register in
// the cycle after that. The rate is set by the checker state update, a single
// pass of range compares between the input register and the state and result
// registers. A pending verdict holds back only final bytes; other bytes keep
// flowing.
module utf8_text_validator_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_string_valid
);

  logic                  s1_valid_r;
  logic [7:0]            s1_byte_r;
  logic                  s1_final_r;
  logic                  s1_adv;
  logic                  in_acc;
  utf8v_pkg::chk_state_t state_r;
  utf8v_pkg::chk_state_t state_nxt;
  logic                  verdict;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  out_string_valid_r;

  assign s1_adv   = s1_valid_r && (!s1_final_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r  <= in_text_byte;
      s1_final_r <= in_final_byte;
    end
  end

  utf8v_step u_step (
    .state_i   (state_r),
    .byte_i    (s1_byte_r),
    .final_i   (s1_final_r),
    .state_o   (state_nxt),
    .verdict_o (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= utf8v_pkg::STATE_IDLE;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_final_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_final_r) begin
      out_string_valid_r <= verdict;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_string_valid = out_string_valid_r;

`ifndef NO_ASSERTIONS
  a_rng_needs_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.rng != utf8v_pkg::RNG_ANY) |-> (state_r.cont_left != 2'd0))
    else $error("continuation range set with no continuation pending");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.failed && !(s1_adv && s1_final_r)) |=> state_r.failed)
    else $error("failure flag cleared before the final byte");

  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !(s1_adv && s1_final_r)) |=> !out_valid_r)
    else $error("verdict beat without a final byte");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_final_r) |=> (state_r == utf8v_pkg::STATE_IDLE))
    else $error("state not cleared after the final byte");
`endif

endmodule

[tb/utf8_verdict_checker.sv]
// ----------------------------------------------------------------------------
// UTF-8 verdict checker
// Watches the byte and verdict channels of the UTF-8 validator, tracks the
// decoder state for every accepted byte beat, and compares each verdict beat
// against the oldest predicted verdict.
// ----------------------------------------------------------------------------
module utf8_verdict_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_final_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_string_valid,
  output int unsigned mismatches,
  output int unsigned pending
);

  logic [1:0]      cont_left = 2'd0;
  utf8v_pkg::rng_t next_rng = utf8v_pkg::RNG_ANY;
  logic            failed = 1'b0;
  logic            verdict_q[$];
  int unsigned     err_cnt = 0;

  always @(posedge clk) begin : predict_and_compare
    logic       in_range;
    logic       want_valid;
    logic [7:0] b;
    if (!rst_n) begin
      cont_left = 2'd0;
      next_rng = utf8v_pkg::RNG_ANY;
      failed = 1'b0;
      verdict_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        b = in_text_byte;
        if (!failed) begin
          if (cont_left != 2'd0) begin
            unique case (next_rng)
              utf8v_pkg::RNG_E0, utf8v_pkg::RNG_C2:
                in_range = (b >= utf8v_pkg::BYTE_A0) && (b <= utf8v_pkg::BYTE_CONT_HI);
              utf8v_pkg::RNG_ED:
                in_range = (b >= utf8v_pkg::BYTE_CONT_LO) && (b <= utf8v_pkg::BYTE_9F);
              utf8v_pkg::RNG_F0:
                in_range = (b >= utf8v_pkg::BYTE_90) && (b <= utf8v_pkg::BYTE_CONT_HI);
              utf8v_pkg::RNG_F4:
                in_range = (b >= utf8v_pkg::BYTE_CONT_LO) && (b <= utf8v_pkg::BYTE_8F);
              default:
                in_range = (b >= utf8v_pkg::BYTE_CONT_LO) && (b <= utf8v_pkg::BYTE_CONT_HI);
            endcase
            if (in_range) begin
              cont_left = cont_left - 2'd1;
              next_rng = utf8v_pkg::RNG_ANY;
            end else begin
              failed = 1'b1;
            end
          end else if (b < utf8v_pkg::BYTE_CONT_LO) begin
            if (b < utf8v_pkg::BYTE_SPACE || b == utf8v_pkg::BYTE_DEL) failed = 1'b1;
          end else if (b >= utf8v_pkg::LEAD2_LO && b <= utf8v_pkg::LEAD2_HI) begin
            cont_left = 2'd1;
            next_rng = (b == utf8v_pkg::LEAD2_LO) ? utf8v_pkg::RNG_C2 : utf8v_pkg::RNG_ANY;
          end else if (b >= utf8v_pkg::LEAD3_LO && b <= utf8v_pkg::LEAD3_HI) begin
            cont_left = 2'd2;
            if (b == utf8v_pkg::LEAD3_LO) next_rng = utf8v_pkg::RNG_E0;
            else if (b == utf8v_pkg::LEAD3_SURR) next_rng = utf8v_pkg::RNG_ED;
            else next_rng = utf8v_pkg::RNG_ANY;
          end else if (b >= utf8v_pkg::LEAD4_LO && b <= utf8v_pkg::LEAD4_HI) begin
            cont_left = 2'd3;
            if (b == utf8v_pkg::LEAD4_LO) next_rng = utf8v_pkg::RNG_F0;
            else if (b == utf8v_pkg::LEAD4_HI) next_rng = utf8v_pkg::RNG_F4;
            else next_rng = utf8v_pkg::RNG_ANY;
          end else begin
            failed = 1'b1;
          end
        end
        if (in_final_byte) begin
          verdict_q.push_back(!failed && cont_left == 2'd0);
          cont_left = 2'd0;
          next_rng = utf8v_pkg::RNG_ANY;
          failed = 1'b0;
        end
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("string_valid: no verdict expected, got %0b", out_string_valid);
          err_cnt++;
        end else begin
          want_valid = verdict_q.pop_front();
          if (out_string_valid !== want_valid) begin
            $error("string_valid: expected %0b, got %0b", want_valid, out_string_valid);
            err_cnt++;
          end
        end
      end
    end
    mismatches <= err_cnt;
    pending <= verdict_q.size();
  end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// UTF-8 validator testbench
// Drives byte strings into the validator, first a directed set of boundary
// and error cases and then random strings built mostly from well-formed
// characters with some noise, truncation and damage, under random idling on
// both channels and one long verdict stall. A checker module predicts and
// compares every verdict beat.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned RandomItems = 1250;
  localparam int unsigned LongHoldBeat = 40;
  localparam int unsigned LongHoldCycles = 400;

  localparam logic [8:0] DIRECTED [26] = '{
    {1'b1, 8'h00}, {1'b1, 8'h7F}, {1'b1, 8'h20}, {1'b1, 8'hFF},
    {1'b0, 8'hC2}, {1'b1, 8'h80},
    {1'b0, 8'hDF}, {1'b1, 8'hBF},
    {1'b0, 8'hE0}, {1'b0, 8'h9F}, {1'b1, 8'h80},
    {1'b0, 8'hED}, {1'b0, 8'hA0}, {1'b1, 8'h80},
    {1'b0, 8'hF4}, {1'b0, 8'h90}, {1'b0, 8'h80}, {1'b1, 8'h80},
    {1'b0, 8'hF0}, {1'b0, 8'h90}, {1'b0, 8'h80}, {1'b1, 8'h80},
    {1'b0, 8'hE2}, {1'b1, 8'h82},
    {1'b0, 8'h80}, {1'b1, 8'h41}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_text_byte = 8'h00;
  logic        in_final_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_string_valid;
  int unsigned mismatches;
  int unsigned pending;
  bit          no_idle = 1'b0;

  always #6 clk = ~clk;

  utf8_text_validator_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_final_byte    (in_final_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_string_valid (out_string_valid)
  );

  utf8_verdict_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_final_byte    (in_final_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_string_valid (out_string_valid),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_final_byte <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin : stimulus
    logic [7:0]  str_bytes[$];
    logic [7:0]  lead;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  first_cont;
    int unsigned n_chars;
    int unsigned n_cont;
    int unsigned kind;
    int unsigned items_sent;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 26; i++) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    items_sent = 0;
    while (items_sent < RandomItems) begin
      str_bytes.delete();
      n_chars = $urandom_range(1, 8);
      for (int c = 0; c < n_chars; c++) begin
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
          str_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 45) begin
          str_bytes.push_back(8'($urandom_range(utf8v_pkg::BYTE_SPACE,
                                                utf8v_pkg::BYTE_DEL - 8'd1)));
        end else begin
          n_cont = (kind < 65) ? 1 : (kind < 85) ? 2 : 3;
          case (n_cont)
            1:       lead = 8'($urandom_range(utf8v_pkg::LEAD2_LO, utf8v_pkg::LEAD2_HI));
            2:       lead = 8'($urandom_range(utf8v_pkg::LEAD3_LO, utf8v_pkg::LEAD3_HI));
            default: lead = 8'($urandom_range(utf8v_pkg::LEAD4_LO, utf8v_pkg::LEAD4_HI));
          endcase
          lo = utf8v_pkg::BYTE_CONT_LO;
          hi = utf8v_pkg::BYTE_CONT_HI;
          if (lead == utf8v_pkg::LEAD2_LO || lead == utf8v_pkg::LEAD3_LO) lo = utf8v_pkg::BYTE_A0;
          else if (lead == utf8v_pkg::LEAD4_LO) lo = utf8v_pkg::BYTE_90;
          else if (lead == utf8v_pkg::LEAD3_SURR) hi = utf8v_pkg::BYTE_9F;
          else if (lead == utf8v_pkg::LEAD4_HI) hi = utf8v_pkg::BYTE_8F;
          first_cont = 8'($urandom_range(lo, hi));
          if ($urandom_range(0, 9) == 0) first_cont = $urandom_range(0, 1) ? lo - 8'd1 : hi + 8'd1;
          str_bytes.push_back(lead);
          str_bytes.push_back(first_cont);
          for (int k = 1; k < n_cont; k++)
            str_bytes.push_back(8'($urandom_range(utf8v_pkg::BYTE_CONT_LO,
                                                  utf8v_pkg::BYTE_CONT_HI)));
        end
      end
      kind = $urandom_range(0, 9);
      if (kind == 0 && str_bytes.size() > 1) begin
        void'(str_bytes.pop_back());
      end else if (kind == 1) begin
        str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 15) == 0) no_idle <= ~no_idle;
      foreach (str_bytes[k]) send_byte(str_bytes[k], k == str_bytes.size() - 1);
      items_sent += str_bytes.size();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin : verdict_receiver
    int unsigned wait_cycles;
    int unsigned beats;
    beats = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (beats == LongHoldBeat) wait_cycles = LongHoldCycles;
      else wait_cycles = no_idle ? 0 : $urandom_range(0, 8);
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      beats++;
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
